// File: rtl/sdsr_pkg.sv
// shared constants and controller/datapath command types for the
// ship/drrip stream replacement core; no dependencies
package sdsr_pkg;

	localparam int NUM_SETS      = 2048;
	localparam int NUM_WAYS      = 16;
	localparam int REUSE_ENTRIES = 16384;
	localparam int LEADERS       = 64;

	localparam int SET_W  = $clog2(NUM_SETS);
	localparam int WAY_W  = $clog2(NUM_WAYS);
	localparam int RIDX_W = $clog2(REUSE_ENTRIES);
	localparam int SIG_W  = 4;
	localparam int RRPV_W = 2;
	localparam int CLR_W  = RIDX_W;
	localparam int DET_W  = 37;
	localparam int PSEL_W = 10;

	localparam logic [PSEL_W-1:0] PSEL_RESET = 10'd512;
	localparam logic [PSEL_W-1:0] PSEL_MAX   = 10'd1023;
	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;
	localparam logic [RRPV_W-1:0] RRPV_DISTANT = 2'd3;
	localparam logic [RRPV_W-1:0] RRPV_LONG    = 2'd2;
	localparam logic [RRPV_W-1:0] RRPV_NEAR    = 2'd0;
	localparam logic [1:0] REUSE_INIT = 2'd1;

	localparam logic KIND_HIT  = 1'b0;
	localparam logic KIND_MISS = 1'b1;

	typedef struct packed {
		logic              latch;
		logic              rd;
		logic              calc;
		logic              evict;
		logic              clear_wr;
		logic [CLR_W-1:0]  clear_addr;
		logic              load_out;
	} cmd_t;

	typedef struct packed {
		logic evict_needed;
	} status_t;

endpackage

// File: rtl/sdsr_if.sv
// access and result channel interfaces of the replacement core
// depends on nothing
interface sdsr_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [10:0] set_index;
	logic [3:0]  way_hit;
	logic [23:0] pc;
	logic [63:0] block_address;
	logic [15:0] valid_mask;
	modport source(output valid, kind, set_index, way_hit, pc, block_address, valid_mask,
		input ready);
	modport sink(input valid, kind, set_index, way_hit, pc, block_address, valid_mask,
		output ready);
endinterface

interface sdsr_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] victim_way;
	logic [1:0] inserted_rrpv;
	logic       streaming_mode;
	modport source(output valid, victim_way, inserted_rrpv, streaming_mode, input ready);
	modport sink(input valid, victim_way, inserted_rrpv, streaming_mode, output ready);
endinterface

// File: rtl/sdsr_ram.sv
// generic simple dual-port ram, one write and one registered read port
// depends on nothing
module sdsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/sdsr_ctrl.sv
// sequencer of the replacement core: clearing pass, per-access steps,
// result register handshake; depends on sdsr_pkg
module sdsr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output sdsr_pkg::cmd_t   cmd,
	input  sdsr_pkg::status_t status
);
	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_READ, ST_CALC, ST_EVICT, ST_DONE
	} state_t;

	state_t state_q;
	logic [sdsr_pkg::CLR_W-1:0] clr_q;
	logic out_valid_q;
	logic load;

	assign load      = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.latch      = in_valid && in_ready;
		cmd.rd         = (state_q == ST_READ);
		cmd.calc       = (state_q == ST_CALC);
		cmd.evict      = (state_q == ST_EVICT);
		cmd.clear_wr   = (state_q == ST_CLEAR);
		cmd.clear_addr = clr_q;
		cmd.load_out   = load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load || (out_valid_q && !out_ready);
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == sdsr_pkg::CLR_W'(sdsr_pkg::REUSE_ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_READ;
					end
				end
				ST_READ:  state_q <= ST_CALC;
				ST_CALC:  state_q <= status.evict_needed ? ST_EVICT : ST_DONE;
				ST_EVICT: state_q <= ST_DONE;
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ready)
		else $error("access taken during clearing pass");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("waiting word dropped");
	a_evict_after_calc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVICT) |-> ($past(state_q) == ST_CALC))
		else $error("evict step out of order");
	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!out_valid_q || out_ready))
		else $error("result overwritten");
endmodule

// File: rtl/sdsr_datapath.sv
// metadata memories, victim selection, stride detector, insertion policy
// depends on sdsr_pkg and sdsr_ram
module sdsr_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  sdsr_pkg::cmd_t    cmd,
	output sdsr_pkg::status_t status,
	input  logic              in_kind,
	input  logic [10:0]       in_set_index,
	input  logic [3:0]        in_way_hit,
	input  logic [23:0]       in_pc,
	input  logic [63:0]       in_block_address,
	input  logic [15:0]       in_valid_mask,
	output logic [3:0]        victim_way,
	output logic [1:0]        inserted_rrpv,
	output logic              streaming_mode
);
	localparam int NW = sdsr_pkg::NUM_WAYS;
	localparam int SW = sdsr_pkg::SET_W;
	localparam int WW = sdsr_pkg::WAY_W;
	localparam int RW = sdsr_pkg::RIDX_W;
	localparam int GW = sdsr_pkg::SIG_W;

	// latched access
	logic          kind_q;
	logic [SW-1:0] set_q;
	logic [WW-1:0] way_q;
	logic [GW-1:0] sig_q;
	logic [7:0]    blk_q;
	logic [NW-1:0] valid_q;

	logic [15:0] lfsr_q;
	logic [sdsr_pkg::PSEL_W-1:0] psel_q;
	logic [RW-1:0] ev_idx_q;
	logic [3:0]    res_way_q;
	logic [1:0]    res_ins_q;
	logic          res_stream_q;

	logic [NW*2-1:0]  rrpv_rd, rrpv_wd;
	logic [NW*GW-1:0] sig_rd, sig_wd;
	logic [sdsr_pkg::DET_W-1:0] det_rd, det_wd;
	logic [1:0] reuse_rd, reuse_wd;
	logic [SW-1:0] set_waddr;
	logic [RW-1:0] reuse_waddr, reuse_raddr, idx, ev_idx;
	logic set_we, reuse_we;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q  <= in_kind;
			set_q   <= SW'(in_set_index);
			way_q   <= WW'(in_way_hit);
			sig_q   <= GW'(in_pc ^ (in_pc >> 8) ^ (in_pc >> 16));
			blk_q   <= in_block_address[13:6];
			for (int w = 0; w < NW; w++) begin
				valid_q[w] <= (w >= 16) ? 1'b1 : in_valid_mask[w % 16];
			end
		end
	end

	assign idx = RW'({set_q, sig_q});

	// victim choice
	logic [1:0] r [NW];
	logic [1:0] maxv;
	logic any_inv, any3, any2, any1, stream_old;
	logic [WW-1:0] first_inv, first_max, victim;
	logic [NW*2-1:0] aged;
	always_comb begin
		any_inv = 1'b0; any3 = 1'b0; any2 = 1'b0; any1 = 1'b0;
		first_inv = '0; first_max = '0;
		for (int w = 0; w < NW; w++) begin
			r[w] = rrpv_rd[2*w +: 2];
			any_inv |= !valid_q[w];
			any3 |= (r[w] == 2'd3);
			any2 |= (r[w] == 2'd2);
			any1 |= (r[w] == 2'd1);
		end
		maxv = any3 ? 2'd3 : any2 ? 2'd2 : any1 ? 2'd1 : 2'd0;
		for (int w = NW - 1; w >= 0; w--) begin
			if (!valid_q[w]) first_inv = WW'(w);
			if (r[w] == maxv) first_max = WW'(w);
		end
		aged = rrpv_rd;
		stream_old = (det_rd[27:26] == 2'd3);
		if (any_inv) begin
			victim = first_inv;
		end else if (stream_old) begin
			victim = any3 ? first_max : '0;
			if (!any3) begin
				for (int w = 0; w < NW; w++) aged[2*w +: 2] = r[w] + 2'd1;
			end
		end else begin
			victim = first_max;
			for (int w = 0; w < NW; w++) aged[2*w +: 2] = r[w] + (2'd3 - maxv);
		end
	end

	// stride detector: hist[23:0] ptr[25:24] score[27:26] prev[35:28] seen[36]
	logic [23:0] hist_new;
	logic [1:0]  ptr_p, ptr_new, score_new;
	logic [7:0]  delta;
	logic        regular;
	always_comb begin
		ptr_p     = (det_rd[25:24] == 2'd3) ? 2'd0 : det_rd[25:24];
		delta     = blk_q - det_rd[35:28];
		hist_new  = det_rd[23:0];
		ptr_new   = det_rd[25:24];
		score_new = det_rd[27:26];
		if (det_rd[36]) begin
			unique case (ptr_p)
				2'd0:    hist_new[7:0]   = delta;
				2'd1:    hist_new[15:8]  = delta;
				default: hist_new[23:16] = delta;
			endcase
			ptr_new = (ptr_p == 2'd2) ? 2'd0 : ptr_p + 2'd1;
			regular = (hist_new[7:0] == hist_new[15:8]) && (hist_new[7:0] == hist_new[23:16])
				&& (hist_new[7:0] != 8'd0);
			if (regular) begin
				if (score_new != 2'd3) score_new = score_new + 2'd1;
			end else if (score_new != 2'd0) begin
				score_new = score_new - 2'd1;
			end
		end else begin
			regular = 1'b0;
		end
		det_wd = {1'b1, blk_q, score_new, ptr_new, hist_new};
	end

	// insertion policy
	logic lead_s, lead_b, stream_new, use_draw, draw_near;
	logic [15:0] lfsr_next;
	logic [1:0] ins;
	assign lead_s     = set_q < SW'(sdsr_pkg::LEADERS);
	assign lead_b     = (set_q >= SW'(sdsr_pkg::NUM_SETS / 2))
		&& ({1'b0, set_q} < (SW + 1)'(sdsr_pkg::NUM_SETS / 2 + sdsr_pkg::LEADERS));
	assign stream_new = (score_new == 2'd3);
	assign lfsr_next  = (lfsr_q >> 1) ^ (lfsr_q[0] ? sdsr_pkg::LFSR_TAPS : 16'd0);
	assign draw_near  = (lfsr_next[4:0] == 5'd0);
	always_comb begin
		use_draw = 1'b0;
		if (stream_new) ins = sdsr_pkg::RRPV_DISTANT;
		else if (lead_s) ins = sdsr_pkg::RRPV_LONG;
		else if (lead_b || (reuse_rd < 2'd2 && psel_q < sdsr_pkg::PSEL_RESET)) begin
			use_draw = 1'b1;
			ins = draw_near ? sdsr_pkg::RRPV_LONG : sdsr_pkg::RRPV_DISTANT;
		end else if (reuse_rd >= 2'd2) ins = sdsr_pkg::RRPV_NEAR;
		else ins = sdsr_pkg::RRPV_LONG;
	end

	logic miss;
	assign miss   = (kind_q == sdsr_pkg::KIND_MISS);
	assign ev_idx = RW'({set_q, sig_rd[GW*victim +: GW]});
	assign status.evict_needed = miss && valid_q[victim];

	// memory write data and addresses
	always_comb begin
		rrpv_wd = miss ? aged : rrpv_rd;
		sig_wd  = sig_rd;
		if (miss) begin
			rrpv_wd[2*victim +: 2] = ins;
			sig_wd[GW*victim +: GW] = sig_q;
		end else begin
			rrpv_wd[2*way_q +: 2] = sdsr_pkg::RRPV_NEAR;
		end
		set_we      = cmd.clear_wr || cmd.calc;
		set_waddr   = cmd.clear_wr ? cmd.clear_addr[SW-1:0] : set_q;
		reuse_raddr = cmd.calc ? ev_idx : idx;
		reuse_we    = cmd.clear_wr || (cmd.calc && !miss) || cmd.evict;
		reuse_waddr = cmd.clear_wr ? cmd.clear_addr : cmd.evict ? ev_idx_q : idx;
		if (cmd.clear_wr) reuse_wd = sdsr_pkg::REUSE_INIT;
		else if (cmd.evict) reuse_wd = (reuse_rd != 2'd0) ? reuse_rd - 2'd1 : reuse_rd;
		else reuse_wd = (reuse_rd != 2'd3) ? reuse_rd + 2'd1 : reuse_rd;
	end

	sdsr_ram #(.WIDTH(NW * 2), .DEPTH(sdsr_pkg::NUM_SETS)) u_rrpv (
		.clk, .we(set_we), .waddr(set_waddr), .wdata(cmd.clear_wr ? '0 : rrpv_wd),
		.raddr(set_q), .rdata(rrpv_rd));
	sdsr_ram #(.WIDTH(NW * GW), .DEPTH(sdsr_pkg::NUM_SETS)) u_sig (
		.clk, .we(set_we), .waddr(set_waddr), .wdata(cmd.clear_wr ? '0 : sig_wd),
		.raddr(set_q), .rdata(sig_rd));
	sdsr_ram #(.WIDTH(sdsr_pkg::DET_W), .DEPTH(sdsr_pkg::NUM_SETS)) u_det (
		.clk, .we(set_we), .waddr(set_waddr), .wdata(cmd.clear_wr ? '0 : det_wd),
		.raddr(set_q), .rdata(det_rd));
	sdsr_ram #(.WIDTH(2), .DEPTH(sdsr_pkg::REUSE_ENTRIES)) u_reuse (
		.clk, .we(reuse_we), .waddr(reuse_waddr), .wdata(reuse_wd),
		.raddr(reuse_raddr), .rdata(reuse_rd));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= sdsr_pkg::LFSR_SEED;
			psel_q <= sdsr_pkg::PSEL_RESET;
		end else if (cmd.calc && miss) begin
			if (use_draw) lfsr_q <= lfsr_next;
			if (lead_s && lead_b) begin
				// set in both leader groups: down then up, only the floor shows
				if (psel_q == '0) psel_q <= sdsr_pkg::PSEL_W'(1);
			end else begin
				if (lead_s && psel_q != '0) psel_q <= psel_q - 1'b1;
				if (lead_b && psel_q != sdsr_pkg::PSEL_MAX) psel_q <= psel_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			ev_idx_q     <= ev_idx;
			res_way_q    <= 4'(miss ? victim : way_q);
			res_ins_q    <= miss ? ins : sdsr_pkg::RRPV_NEAR;
			res_stream_q <= stream_new;
		end
		if (cmd.load_out) begin
			victim_way     <= res_way_q;
			inserted_rrpv  <= res_ins_q;
			streaming_mode <= res_stream_q;
		end
	end
endmodule

// File: rtl/ship_drrip_stream_replacement_core.sv
// ship/drrip replacement core with per-set stride streaming detector
// accepts one access word on req and returns one result word on rsp.
// an access reads the set's rrpv, signature and detector rows and the reuse
// counter, then picks the victim, updates detector and selector and writes
// the rows back; a miss that evicts a valid line adds an evict step for
// the read-modify-write of the evicted signature's reuse counter.
// from acceptance to result an access passes the read, calc and done steps
// (hit or miss into an invalid way) and also the evict step for a miss that
// evicts a valid line; the single port pair of the reuse counter memory sets
// that extra step. one access is in flight at a time; the next is taken once
// the result sits in the output register.
// after reset a clearing pass over all 16384 reuse counter entries
// initializes all metadata memories; req.ready stays low until it ends.
// when rsp stalls the result word is held in the output register and the
// core waits with the next result until it is taken.
// depends on sdsr_pkg, sdsr_if, sdsr_ctrl, sdsr_datapath, sdsr_ram
module ship_drrip_stream_replacement_core (
	input  logic     clk,
	input  logic     arst_n,
	sdsr_req_if.sink req,
	sdsr_rsp_if.source rsp
);
	sdsr_pkg::cmd_t    cmd;
	sdsr_pkg::status_t status;

	sdsr_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.cmd, .status);

	sdsr_datapath u_dp (
		.clk, .arst_n, .cmd, .status,
		.in_kind(req.kind), .in_set_index(req.set_index), .in_way_hit(req.way_hit),
		.in_pc(req.pc), .in_block_address(req.block_address),
		.in_valid_mask(req.valid_mask),
		.victim_way(rsp.victim_way), .inserted_rrpv(rsp.inserted_rrpv),
		.streaming_mode(rsp.streaming_mode));
endmodule

// File: tb/sv/tb_ship_drrip_stream_replacement_core.sv
// testbench for the ship/drrip stream replacement core: random and directed
// access words checked against an in-bench replacement predictor
// depends on sdsr_pkg, sdsr_if and the core
`timescale 1ns / 1ps

module tb_ship_drrip_stream_replacement_core;

	typedef struct {
		logic        kind;
		logic [10:0] set_index;
		logic [3:0]  way_hit;
		logic [23:0] pc;
		logic [63:0] block_address;
		logic [15:0] valid_mask;
	} access_t;

	typedef struct {
		logic [3:0] victim_way;
		logic [1:0] inserted_rrpv;
		logic       streaming_mode;
	} choice_t;

	// replacement predictor plus store of pending choices
	class replacement_scoreboard;
		logic [1:0]  rrpv [sdsr_pkg::NUM_SETS*sdsr_pkg::NUM_WAYS];
		logic [3:0]  sigs [sdsr_pkg::NUM_SETS*sdsr_pkg::NUM_WAYS];
		logic [1:0]  reuse [sdsr_pkg::REUSE_ENTRIES];
		logic [9:0]  psel;
		logic [23:0] hist [sdsr_pkg::NUM_SETS];
		logic [1:0]  ptr [sdsr_pkg::NUM_SETS];
		logic [1:0]  score [sdsr_pkg::NUM_SETS];
		logic [7:0]  prev_low [sdsr_pkg::NUM_SETS];
		logic        seen [sdsr_pkg::NUM_SETS];
		logic [15:0] lfsr;
		choice_t     pending [$];
		int          errors;

		function new();
			foreach (rrpv[i]) begin
				rrpv[i] = 2'd0;
				sigs[i] = 4'd0;
			end
			foreach (reuse[i]) reuse[i] = sdsr_pkg::REUSE_INIT;
			foreach (hist[i]) begin
				hist[i] = 24'd0;
				ptr[i] = 2'd0;
				score[i] = 2'd0;
				prev_low[i] = 8'd0;
				seen[i] = 1'b0;
			end
			psel = sdsr_pkg::PSEL_RESET;
			lfsr = sdsr_pkg::LFSR_SEED;
			errors = 0;
		endfunction

		function bit draw_near();
			bit lsb;
			lsb = lfsr[0];
			lfsr = lfsr >> 1;
			if (lsb) lfsr ^= sdsr_pkg::LFSR_TAPS;
			return lfsr[4:0] == 5'd0;
		endfunction

		function void track_stride(int s, logic [63:0] addr);
			logic [7:0] low, d;
			int p;
			low = addr[13:6];
			if (seen[s]) begin
				d = low - prev_low[s];
				p = ptr[s] % 3;
				hist[s][8*p +: 8] = d;
				ptr[s] = 2'((p + 1) % 3);
				if (hist[s][7:0] == hist[s][15:8] && hist[s][7:0] == hist[s][23:16]
						&& hist[s][7:0] != 8'd0) begin
					if (score[s] < 3) score[s]++;
				end else if (score[s] > 0) begin
					score[s]--;
				end
			end
			prev_low[s] = low;
			seen[s] = 1'b1;
		endfunction

		function int pick_victim(int s, logic [15:0] mask);
			int b, maxv;
			b = s * sdsr_pkg::NUM_WAYS;
			maxv = 0;
			for (int w = 0; w < sdsr_pkg::NUM_WAYS; w++)
				if (!mask[w]) return w;
			if (score[s] == 3) begin
				for (int w = 0; w < sdsr_pkg::NUM_WAYS; w++)
					if (rrpv[b+w] == 3) return w;
				for (int w = 0; w < sdsr_pkg::NUM_WAYS; w++)
					if (rrpv[b+w] < 3) rrpv[b+w]++;
				return 0;
			end
			for (int w = 0; w < sdsr_pkg::NUM_WAYS; w++)
				if (rrpv[b+w] > maxv) maxv = rrpv[b+w];
			for (int w = 0; w < sdsr_pkg::NUM_WAYS; w++)
				rrpv[b+w] = 2'(rrpv[b+w] + (3 - maxv));
			for (int w = 0; w < sdsr_pkg::NUM_WAYS; w++)
				if (rrpv[b+w] == 3) return w;
			return 0;
		endfunction

		function void note_access(access_t a);
			int s, idx, way, line;
			logic [3:0] sig, old_sig;
			logic [1:0] ins;
			bit lead_s, lead_b, was_valid;
			choice_t c;
			s = a.set_index;
			sig = a.pc[3:0] ^ a.pc[11:8] ^ a.pc[19:16];
			idx = ((s << 4) | sig) % sdsr_pkg::REUSE_ENTRIES;
			if (a.kind == sdsr_pkg::KIND_HIT) begin
				way = a.way_hit;
				track_stride(s, a.block_address);
				rrpv[s*sdsr_pkg::NUM_WAYS + way] = sdsr_pkg::RRPV_NEAR;
				if (reuse[idx] < 3) reuse[idx]++;
				ins = sdsr_pkg::RRPV_NEAR;
			end else begin
				lead_s = s < sdsr_pkg::LEADERS;
				lead_b = s >= sdsr_pkg::NUM_SETS/2
					&& s < sdsr_pkg::NUM_SETS/2 + sdsr_pkg::LEADERS;
				way = pick_victim(s, a.valid_mask);
				was_valid = a.valid_mask[way];
				line = s*sdsr_pkg::NUM_WAYS + way;
				old_sig = sigs[line];
				track_stride(s, a.block_address);
				sigs[line] = sig;
				if (score[s] == 3) ins = sdsr_pkg::RRPV_DISTANT;
				else if (lead_s) ins = sdsr_pkg::RRPV_LONG;
				else if (lead_b)
					ins = draw_near() ? sdsr_pkg::RRPV_LONG : sdsr_pkg::RRPV_DISTANT;
				else if (reuse[idx] >= 2) ins = sdsr_pkg::RRPV_NEAR;
				else if (psel >= sdsr_pkg::PSEL_RESET) ins = sdsr_pkg::RRPV_LONG;
				else ins = draw_near() ? sdsr_pkg::RRPV_LONG : sdsr_pkg::RRPV_DISTANT;
				rrpv[line] = ins;
				if (lead_s && psel > 0) psel--;
				if (lead_b && psel < sdsr_pkg::PSEL_MAX) psel++;
				if (was_valid) begin
					idx = ((s << 4) | old_sig) % sdsr_pkg::REUSE_ENTRIES;
					if (reuse[idx] > 0) reuse[idx]--;
				end
			end
			c.victim_way = 4'(way);
			c.inserted_rrpv = ins;
			c.streaming_mode = score[s] == 3;
			pending = {pending, c};
		endfunction

		function void check_choice(choice_t got);
			choice_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word way=%0d rrpv=%0d stream=%0d", $time,
					got.victim_way, got.inserted_rrpv, got.streaming_mode);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.victim_way !== e.victim_way) begin
				$display("%0t: victim_way expected %0d actual %0d", $time,
					e.victim_way, got.victim_way);
				errors++;
			end
			if (got.inserted_rrpv !== e.inserted_rrpv) begin
				$display("%0t: inserted_rrpv expected %0d actual %0d", $time,
					e.inserted_rrpv, got.inserted_rrpv);
				errors++;
			end
			if (got.streaming_mode !== e.streaming_mode) begin
				$display("%0t: streaming_mode expected %0d actual %0d", $time,
					e.streaming_mode, got.streaming_mode);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 1;
	bit   quiet = 0;
	replacement_scoreboard sb = new();

	sdsr_req_if req();
	sdsr_rsp_if rsp();

	ship_drrip_stream_replacement_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	initial begin
		req.valid = 0;
		req.kind = 0;
		req.set_index = 0;
		req.way_hit = 0;
		req.pc = 0;
		req.block_address = 0;
		req.valid_mask = 0;
		rsp.ready = 0;
	end

	// result side: random stall bursts, none late in the run
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_choice('{rsp.victim_way, rsp.inserted_rrpv, rsp.streaming_mode});
	end

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				rsp.ready <= 0;
				n = $urandom_range(1, 16);
				repeat (n) @(posedge clk);
			end
			rsp.ready <= 1;
		end
	end

	// valid stays high between back-to-back words, drops only for an idle burst
	task automatic send_access(access_t a);
		int n;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			req.valid <= 0;
			n = $urandom_range(1, 16);
			repeat (n) @(posedge clk);
		end
		req.valid <= 1;
		req.kind <= a.kind;
		req.set_index <= a.set_index;
		req.way_hit <= a.way_hit;
		req.pc <= a.pc;
		req.block_address <= a.block_address;
		req.valid_mask <= a.valid_mask;
		do @(posedge clk); while (!req.ready);
		sb.note_access(a);
	endtask

	function automatic access_t rand_access(int s, logic [63:0] addr);
		access_t a;
		a.kind = $urandom_range(0, 2) != 0;
		a.set_index = 11'(s);
		a.way_hit = 4'($urandom);
		a.pc = 24'($urandom);
		a.block_address = addr;
		case ($urandom_range(0, 3))
			0: a.valid_mask = 16'($urandom);
			1: a.valid_mask = 16'hFFFF & ~(16'h1 << $urandom_range(0, 15));
			default: a.valid_mask = 16'hFFFF;
		endcase
		return a;
	endfunction

	initial begin
		access_t a;
		logic [63:0] addr;
		logic [7:0] stride;
		int s, len;
		int sets[8];
		arst_n <= 0;
		sets = '{0, 63, 64, 1023, 1024, 1087, 1088, 2047};
		repeat (3) @(posedge clk);
		arst_n <= 1;
		// directed: leader and follower edges, hits, full and empty masks
		foreach (sets[i]) begin
			send_access('{sdsr_pkg::KIND_MISS, 11'(sets[i]), 4'hF, 24'hFFFFFF,
				64'hFFFF_FFFF_FFFF_FFFF, 16'h0000});
			send_access('{sdsr_pkg::KIND_MISS, 11'(sets[i]), 4'h0, 24'h000000, 64'h0,
				16'hFFFF});
		end
		send_access('{sdsr_pkg::KIND_HIT, 11'd5, 4'hF, 24'h123456, 64'h40, 16'hFFFF});
		send_access('{sdsr_pkg::KIND_HIT, 11'd5, 4'h0, 24'hABCDEF, 64'h80, 16'h0});
		// stride stream to saturate the detector
		for (int i = 0; i < 8; i++)
			send_access('{sdsr_pkg::KIND_MISS, 11'd700, 4'h0, 24'h55AA55,
				64'h1000 + i*64*3, 16'hFFFF});
		// random: mostly strided runs in a few hot sets, some noise
		for (int k = 0; k < 1500; ) begin
			s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
				: sets[$urandom_range(0, 7)] + $urandom_range(0, 3) % 2;
			addr = {$urandom, $urandom};
			stride = $urandom_range(0, 4) == 0 ? 8'($urandom) : 8'($urandom_range(1, 3));
			len = $urandom_range(1, 10);
			if (k > 1300) quiet = 1;
			for (int j = 0; j < len; j++, k++) begin
				a = rand_access(s, addr);
				send_access(a);
				addr = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom}
					: addr + {stride, 6'd0};
			end
		end
		req.valid <= 0;
		quiet = 1;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("[ship_drrip_stream_replacement_core] OK");
		else
			$display("[ship_drrip_stream_replacement_core] ERROR");
		$finish;
	end

	initial begin
		#5ms;
		$display("[ship_drrip_stream_replacement_core] ERROR");
		$finish;
	end

endmodule
